// ----- rtl/core/uvm_pkg.sv -----
package uvm_pkg;

  localparam int FIELD_W = 24;
  localparam int ANG_W   = 34;
  localparam int CORD_W  = 28;
  localparam int SQ_W    = 48;
  localparam int ROOT_W  = 24;
  localparam int QW      = 27;
  localparam int WIDE_W  = 40;
  localparam int IDX_W   = 8;

  localparam logic [IDX_W-1:0] REG_MAP_TYPE  = 8'd0;
  localparam logic [IDX_W-1:0] REG_FACE_TOL  = 8'd1;

  typedef enum logic [1:0] {
    MAP_SPHERE   = 2'd0,
    MAP_PLANE    = 2'd1,
    MAP_CYLINDER = 2'd2,
    MAP_CUBOID   = 2'd3
  } map_t;

  typedef logic signed [FIELD_W-1:0] coord_t;

  typedef struct packed {
    map_t   map;
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t u_alt;
    coord_t v_alt;
  } side_t;

  // atan(2^-i) in units of pi / 2^31
  function automatic logic signed [ANG_W-1:0] atan_ang(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      24: t = 32'h00000029;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      28: t = 32'h00000003;
      29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return signed'({2'b00, t});
  endfunction

  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    if (v > 40'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      return 24'sh800000;
    end
    return v[FIELD_W-1:0];
  endfunction

endpackage

// ----- rtl/core/uv_texture_coordinate_mapper.sv -----
// channel | direction | handshake          | words
// in      | input     | in_valid/in_stall  | x_coord, y_coord, z_coord
// out     | output    | out_valid/out_stall| u_coord, v_coord
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word enters per cycle while in_stall is low; the pipeline runs through the
// front end, one square-root bit per stage, a CORDIC preset, one stage per rotation
// and output rounding. Reset (rst_n low, synchronous) clears all valid bits and
// sets map_type and face_tolerance to zero. A stalled output word freezes the
// whole pipeline and raises in_stall in the same cycle.
module uv_texture_coordinate_mapper #(
  parameter int CORDIC_ITERATIONS = 20,
  parameter int FRAC_BITS         = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  uvm_pkg::coord_t               in_x_coord,
  input  uvm_pkg::coord_t               in_y_coord,
  input  uvm_pkg::coord_t               in_z_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output uvm_pkg::coord_t               out_u_coord,
  output uvm_pkg::coord_t               out_v_coord,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uvm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [7:0]                    cfg_data
);
  import uvm_pkg::*;

  localparam int SH = 31 - FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] RND = 40'sd1 <<< (SH - 1);
  localparam logic signed [WIDE_W-1:0] PI  = 40'sd2147483648;

  map_t       map_r;
  logic [7:0] tol_r;
  logic       en;

  logic            f_vld, s_vld, c_vld;
  logic [SQ_W-1:0] f_sum;
  side_t           f_side, s_side, c_side;
  logic [ROOT_W-1:0] s_root;
  logic signed [ANG_W-1:0] ang_xy, ang_rz;

  logic   out_valid_r;
  coord_t u_r, v_r, u_nxt, v_nxt;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= MAP_SPHERE;
      tol_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAP_TYPE: map_r <= map_t'(cfg_data[1:0]);
        REG_FACE_TOL: tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  uvm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .x_in     (in_x_coord),
    .y_in     (in_y_coord),
    .z_in     (in_z_coord),
    .map_in   (map_r),
    .tol_in   (tol_r),
    .out_vld  (f_vld),
    .sum_out  (f_sum),
    .side_out (f_side)
  );

  uvm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .n_in     (f_sum),
    .side_in  (f_side),
    .out_vld  (s_vld),
    .root_out (s_root),
    .side_out (s_side)
  );

  uvm_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s_vld),
    .root_in  (s_root),
    .side_in  (s_side),
    .out_vld  (c_vld),
    .ang_xy   (ang_xy),
    .ang_rz   (ang_rz),
    .side_out (c_side)
  );

  coord_t u_ang, v_ang;
  assign u_ang = sat_coord((WIDE_W'(ang_xy) + RND) >>> SH);
  assign v_ang = sat_coord(((WIDE_W'(ang_rz) <<< 1) - PI + RND) >>> SH);

  always_comb begin
    case (c_side.map)
      MAP_SPHERE: begin
        u_nxt = u_ang;
        v_nxt = v_ang;
      end
      MAP_CYLINDER: begin
        u_nxt = u_ang;
        v_nxt = c_side.v_alt;
      end
      default: begin
        u_nxt = c_side.u_alt;
        v_nxt = c_side.v_alt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_u_coord = u_r;
  assign out_v_coord = v_r;

endmodule

// ----- rtl/core/uvm_front.sv -----
module uvm_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  uvm_pkg::coord_t       x_in,
  input  uvm_pkg::coord_t       y_in,
  input  uvm_pkg::coord_t       z_in,
  input  uvm_pkg::map_t         map_in,
  input  logic [7:0]            tol_in,
  output logic                  out_vld,
  output logic [uvm_pkg::SQ_W-1:0] sum_out,
  output uvm_pkg::side_t        side_out
);
  import uvm_pkg::*;

  localparam logic signed [QW-1:0] ONE = 27'sd1 <<< FRAC_BITS;
  localparam logic signed [QW-1:0] Q1  = ONE >>> 2;
  localparam logic signed [QW-1:0] HLF = ONE >>> 1;
  localparam logic signed [QW-1:0] Q3  = (ONE >>> 1) + (ONE >>> 2);

  // stage 0: input capture
  logic   v0_r, v1_r, v2_r;
  coord_t x0_r, y0_r, z0_r;
  map_t   map0_r;
  logic [7:0] tol0_r;

  // stage 1: squares, face tests, quarters
  logic signed [SQ_W-1:0] sqx_r, sqy_r;
  logic [5:0] near_r;
  logic signed [QW-1:0] qx_r, qy_r, qnx_r, qny_r, qnz_r;
  coord_t x1_r, y1_r, z1_r, nz1_r;
  map_t   map1_r;

  logic [SQ_W-1:0] sum_r;
  side_t side_r;

  logic signed [SQ_W-1:0] sqx_nxt, sqy_nxt;
  logic signed [QW-1:0] xe, ye, ze, tol_s;
  logic [5:0] near_nxt;

  assign sqx_nxt = x0_r * x0_r;
  assign sqy_nxt = y0_r * y0_r;
  assign xe = QW'(x0_r);
  assign ye = QW'(y0_r);
  assign ze = QW'(z0_r);
  assign tol_s = signed'({19'd0, tol0_r});

  function automatic logic near_f(input logic signed [QW-1:0] c,
                                  input logic signed [QW-1:0] t,
                                  input logic signed [QW-1:0] tol);
    logic signed [QW-1:0] d;
    d = c - t;
    return (d <= tol) && (d >= -tol);
  endfunction

  always_comb begin
    near_nxt[0] = near_f(xe, -ONE, tol_s);
    near_nxt[1] = near_f(xe,  ONE, tol_s);
    near_nxt[2] = near_f(ye, -ONE, tol_s);
    near_nxt[3] = near_f(ye,  ONE, tol_s);
    near_nxt[4] = near_f(ze, -ONE, tol_s);
    near_nxt[5] = near_f(ze,  ONE, tol_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= x_in;
      y0_r   <= y_in;
      z0_r   <= z_in;
      map0_r <= map_in;
      tol0_r <= tol_in;

      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      near_r <= near_nxt;
      qx_r   <= (xe + 27'sd2) >>> 2;
      qy_r   <= (ye + 27'sd2) >>> 2;
      qnx_r  <= (27'sd2 - xe) >>> 2;
      qny_r  <= (27'sd2 - ye) >>> 2;
      qnz_r  <= (27'sd2 - ze) >>> 2;
      x1_r   <= x0_r;
      y1_r   <= y0_r;
      z1_r   <= z0_r;
      nz1_r  <= sat_coord(-WIDE_W'(z0_r));
      map1_r <= map0_r;
    end
  end

  side_t side_nxt;
  logic signed [QW-1:0] cu, cv;

  always_comb begin
    cu = '0;
    cv = '0;
    if (near_r[0]) begin
      cu = qny_r - Q3;  cv = qnz_r;
    end else if (near_r[1]) begin
      cu = qy_r + Q1;   cv = qnz_r;
    end else if (near_r[2]) begin
      cu = qx_r - Q1;   cv = qnz_r - HLF;
    end else if (near_r[3]) begin
      cu = qnx_r - Q1;  cv = qnz_r + HLF;
    end else if (near_r[4]) begin
      cu = qx_r + Q3;   cv = qy_r;
    end else if (near_r[5]) begin
      cu = qx_r - Q1;   cv = qy_r;
    end
    side_nxt.map = map1_r;
    side_nxt.x   = x1_r;
    side_nxt.y   = y1_r;
    side_nxt.z   = z1_r;
    case (map1_r)
      MAP_PLANE: begin
        side_nxt.u_alt = x1_r;
        side_nxt.v_alt = y1_r;
      end
      MAP_CYLINDER: begin
        side_nxt.u_alt = '0;
        side_nxt.v_alt = nz1_r;
      end
      MAP_CUBOID: begin
        side_nxt.u_alt = sat_coord(WIDE_W'(cu));
        side_nxt.v_alt = sat_coord(WIDE_W'(cv));
      end
      default: begin
        side_nxt.u_alt = '0;
        side_nxt.v_alt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= $unsigned(sqx_r) + $unsigned(sqy_r);
      side_r <= side_nxt;
    end
  end

  assign out_vld  = v2_r;
  assign sum_out  = sum_r;
  assign side_out = side_r;

endmodule

// ----- rtl/core/uvm_isqrt.sv -----
module uvm_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [uvm_pkg::SQ_W-1:0]   n_in,
  input  uvm_pkg::side_t             side_in,
  output logic                       out_vld,
  output logic [uvm_pkg::ROOT_W-1:0] root_out,
  output uvm_pkg::side_t             side_out
);
  import uvm_pkg::*;

  localparam int NS = ROOT_W;

  logic [SQ_W-1:0] rem_r [1:NS];
  logic [SQ_W-1:0] res_r [1:NS];
  logic            vld_r [1:NS];
  side_t           side_r [1:NS];

  // one root bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] rem_i, res_i;
    logic            vld_i;
    side_t           side_i;
    logic [SQ_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_i  = n_in;
      assign res_i  = '0;
      assign vld_i  = in_vld;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k];
      assign res_i  = res_r[k];
      assign vld_i  = vld_r[k];
      assign side_i = side_r[k];
    end

    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_r[k+1] <= rem_i - trial;
          res_r[k+1] <= (res_i >> 1) + BIT;
        end else begin
          rem_r[k+1] <= rem_i;
          res_r[k+1] <= res_i >> 1;
        end
        side_r[k+1] <= side_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_i;
      end
    end
  end

  assign out_vld  = vld_r[NS];
  assign root_out = res_r[NS][ROOT_W-1:0];
  assign side_out = side_r[NS];

endmodule

// ----- rtl/core/uvm_cordic.sv -----
module uvm_cordic #(
  parameter int ITER = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [uvm_pkg::ROOT_W-1:0]        root_in,
  input  uvm_pkg::side_t                    side_in,
  output logic                              out_vld,
  output logic signed [uvm_pkg::ANG_W-1:0]  ang_xy,
  output logic signed [uvm_pkg::ANG_W-1:0]  ang_rz,
  output uvm_pkg::side_t                    side_out
);
  import uvm_pkg::*;

  localparam logic signed [ANG_W-1:0] PI = ANG_W'(64'sd2147483648);

  // lane 1: atan2(y, x), lane 2: atan2(r, z)
  logic signed [CORD_W-1:0] a1_r [0:ITER];
  logic signed [CORD_W-1:0] b1_r [0:ITER];
  logic signed [CORD_W-1:0] a2_r [0:ITER];
  logic signed [CORD_W-1:0] b2_r [0:ITER];
  logic signed [ANG_W-1:0]  c1_r [0:ITER];
  logic signed [ANG_W-1:0]  c2_r [0:ITER];
  logic                     z1_r [0:ITER];
  logic                     z2_r [0:ITER];
  logic                     vld_r [0:ITER];
  side_t                    side_r [0:ITER];

  logic signed [CORD_W-1:0] ax, by, az, br;
  assign ax = CORD_W'(side_in.x);
  assign by = CORD_W'(side_in.y);
  assign az = CORD_W'(side_in.z);
  assign br = signed'(CORD_W'(root_in));

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r[0] <= (ax == '0) && (by == '0);
      z2_r[0] <= (az == '0) && (br == '0);
      if (ax < 0) begin
        a1_r[0] <= -ax;
        b1_r[0] <= -by;
        c1_r[0] <= (by >= 0) ? PI : -PI;
      end else begin
        a1_r[0] <= ax;
        b1_r[0] <= by;
        c1_r[0] <= '0;
      end
      if (az < 0) begin
        a2_r[0] <= -az;
        b2_r[0] <= -br;
        c2_r[0] <= PI;
      end else begin
        a2_r[0] <= az;
        b2_r[0] <= br;
        c2_r[0] <= '0;
      end
      side_r[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ANG = atan_ang(i);

    always_ff @(posedge clk) begin
      if (en) begin
        if (b1_r[i] > 0) begin
          a1_r[i+1] <= a1_r[i] + (b1_r[i] >>> i);
          b1_r[i+1] <= b1_r[i] - (a1_r[i] >>> i);
          c1_r[i+1] <= c1_r[i] + ANG;
        end else begin
          a1_r[i+1] <= a1_r[i] - (b1_r[i] >>> i);
          b1_r[i+1] <= b1_r[i] + (a1_r[i] >>> i);
          c1_r[i+1] <= c1_r[i] - ANG;
        end
        if (b2_r[i] > 0) begin
          a2_r[i+1] <= a2_r[i] + (b2_r[i] >>> i);
          b2_r[i+1] <= b2_r[i] - (a2_r[i] >>> i);
          c2_r[i+1] <= c2_r[i] + ANG;
        end else begin
          a2_r[i+1] <= a2_r[i] - (b2_r[i] >>> i);
          b2_r[i+1] <= b2_r[i] + (a2_r[i] >>> i);
          c2_r[i+1] <= c2_r[i] - ANG;
        end
        z1_r[i+1]   <= z1_r[i];
        z2_r[i+1]   <= z2_r[i];
        side_r[i+1] <= side_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  assign out_vld  = vld_r[ITER];
  assign ang_xy   = z1_r[ITER] ? '0 : c1_r[ITER];
  assign ang_rz   = z2_r[ITER] ? '0 : c2_r[ITER];
  assign side_out = side_r[ITER];

endmodule

// ----- rtl/core/uvm_checker.sv -----
module uvm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input uvm_pkg::coord_t           out_u_coord,
  input uvm_pkg::coord_t           out_v_coord,
  input logic                      out_valid,
  input logic                      out_stall
);

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output word");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_u_coord) && $stable(out_v_coord)))
    else $error("output word changed under stall");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid)
    else $error("input word withdrawn under stall");

endmodule

bind uv_texture_coordinate_mapper uvm_checker u_uvm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_u_coord (out_u_coord),
  .out_v_coord (out_v_coord),
  .out_valid   (out_valid),
  .out_stall   (out_stall)
);
